>>> sv/mlfq_pkg.sv
// Shared types and constants of the multilevel feedback queue scheduler.
package mlfq_pkg;

	localparam int MAX_JOBS   = 16;
	localparam int MAX_LEVELS = 4;
	localparam int BURST_BITS = 16;
	localparam int SLOT_W     = $clog2(MAX_JOBS);
	localparam int LVL_W      = 2;
	localparam int CNT_W      = SLOT_W + 1;
	localparam int BLVL_W     = LVL_W + 1;
	localparam int USED_W     = 16;
	localparam int TAG_W      = 8;
	localparam int TIME_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Outcome codes of a result.
	localparam logic [2:0] OUT_ACCEPTED = 3'd0;
	localparam logic [2:0] OUT_FULL     = 3'd1;
	localparam logic [2:0] OUT_ZERO     = 3'd2;
	localparam logic [2:0] OUT_IDLE     = 3'd3;
	localparam logic [2:0] OUT_RAN      = 3'd4;

	// Opcodes of an input item.
	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_ARRIVE = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOT0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOT1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOT2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOT3 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BOOST  = 3'd5;

	// One entry of the job table.
	typedef struct packed {
		logic [TAG_W-1:0]      tag;
		logic [BURST_BITS-1:0] remaining;
		logic [USED_W-1:0]     used;
		logic                  started;
	} job_rec_t;

endpackage

>>> sv/multilevel_feedback_queue_scheduler.sv
// Top level of the multilevel feedback queue scheduler.
//
//  channel  | handshake                 | payload
//  input    | in_valid / in_ready       | opcode, job_tag, burst_length
//  result   | out_valid / out_ready     | outcome, run_tag, run_level, first_run,
//           |                           | completed, demoted, tick_time
//  config   | cfg_wr_en                 | cfg_index, cfg_data
//
// An arrive needs no further steps: slot search and both memory writes happen on the transfer.
// A tick that runs a job steps through requeue, queue memory read, job table read,
// then the update and write back; an idle tick ends after the requeue and level search.
// A boost walks serially through the queue memory, with a job table read-modify-write
// for each queued job, level by level, before the level search.
// Reset empties all queues and frees all slots at once; no clearing pass is needed.
// A result that is not taken holds the next result back, and input waits until it can go.
module multilevel_feedback_queue_scheduler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                opcode,
	input  logic [mlfq_pkg::TAG_W-1:0]          job_tag,
	input  logic [mlfq_pkg::BURST_BITS-1:0]     burst_length,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [2:0]                          outcome,
	output logic [mlfq_pkg::TAG_W-1:0]          run_tag,
	output logic [mlfq_pkg::LVL_W-1:0]          run_level,
	output logic                                first_run,
	output logic                                completed,
	output logic                                demoted,
	output logic [mlfq_pkg::TIME_W-1:0]         tick_time,
	input  logic                                cfg_wr_en,
	input  logic [mlfq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mlfq_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int QA_W = mlfq_pkg::LVL_W + mlfq_pkg::SLOT_W;

	typedef enum logic [2:0] {
		ST_IDLE, ST_BNEXT, ST_BRDJ, ST_BWR, ST_SEL, ST_RRD, ST_RUN
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [2:0]                      levels_q;
	logic [mlfq_pkg::USED_W-1:0]     allot_q [mlfq_pkg::MAX_LEVELS];
	logic [15:0]                     period_q;
	logic [15:0]                     countdown_q;

	// Queue pointers, slot occupancy, pending requeue and time.
	logic [mlfq_pkg::SLOT_W-1:0]     head_q [mlfq_pkg::MAX_LEVELS];
	logic [mlfq_pkg::CNT_W-1:0]      cnt_q  [mlfq_pkg::MAX_LEVELS];
	logic [mlfq_pkg::MAX_JOBS-1:0]   busy_q;
	logic                            pend_valid_q;
	logic [mlfq_pkg::SLOT_W-1:0]     pend_slot_q;
	logic [mlfq_pkg::LVL_W-1:0]      pend_lvl_q;
	logic [mlfq_pkg::TIME_W-1:0]     time_q;

	// Walk and run bookkeeping.
	logic [mlfq_pkg::BLVL_W-1:0]     blvl_q;
	logic [mlfq_pkg::CNT_W-1:0]      bidx_q;
	logic [mlfq_pkg::SLOT_W-1:0]     slot_q;
	logic [mlfq_pkg::LVL_W-1:0]      run_lvl_q;

	// Memories and their registered read data.
	logic [mlfq_pkg::SLOT_W-1:0]     qmem [2**QA_W];
	mlfq_pkg::job_rec_t              jmem [mlfq_pkg::MAX_JOBS];
	logic [mlfq_pkg::SLOT_W-1:0]     qrd_q;
	mlfq_pkg::job_rec_t              jrd_q;

	logic                            q_we;
	logic [QA_W-1:0]                 q_waddr;
	logic [QA_W-1:0]                 q_raddr;
	logic [mlfq_pkg::SLOT_W-1:0]     q_wdata;
	logic                            j_we;
	logic [mlfq_pkg::SLOT_W-1:0]     j_waddr;
	logic [mlfq_pkg::SLOT_W-1:0]     j_raddr;
	mlfq_pkg::job_rec_t              j_wdata;

	logic                            ofree;
	logic                            in_xfer;
	logic                            res_load;
	logic                            arrive_ok;
	logic                            table_full;
	logic [mlfq_pkg::SLOT_W-1:0]     free_slot;
	logic                            any_ready;
	logic [mlfq_pkg::LVL_W-1:0]      sel_lvl;
	logic [mlfq_pkg::LVL_W-1:0]      walk_lvl;
	logic [2:0]                      k_act;
	logic [mlfq_pkg::BURST_BITS-1:0] rem_n;
	logic [mlfq_pkg::USED_W-1:0]     used_n;
	logic                            done_n;
	logic                            exhaust_n;
	logic [mlfq_pkg::LVL_W-1:0]      new_lvl;
	logic [mlfq_pkg::SLOT_W-1:0]     tail0;

	assign ofree     = !out_valid || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && ofree;
	assign in_xfer   = in_valid && in_ready;
	assign table_full = &busy_q;
	assign arrive_ok = (opcode == mlfq_pkg::OP_ARRIVE) && (burst_length != '0) && !table_full;
	assign walk_lvl  = blvl_q[mlfq_pkg::LVL_W-1:0];
	assign tail0     = head_q[0] + cnt_q[0][mlfq_pkg::SLOT_W-1:0];

	// A new result enters the output register in this cycle.
	assign res_load = (state_q == ST_IDLE && in_xfer && opcode == mlfq_pkg::OP_ARRIVE) ||
		(state_q == ST_SEL && !any_ready && ofree) || (state_q == ST_RUN && ofree);

	// Lowest free slot.
	always_comb begin
		free_slot = '0;
		for (int i = mlfq_pkg::MAX_JOBS - 1; i >= 0; i--) begin
			if (!busy_q[i]) free_slot = mlfq_pkg::SLOT_W'(i);
		end
	end

	// Highest-priority non-empty level, the one with the lowest number.
	always_comb begin
		any_ready = 1'b0;
		sel_lvl   = '0;
		for (int l = mlfq_pkg::MAX_LEVELS - 1; l >= 0; l--) begin
			if (cnt_q[l] != '0) begin
				any_ready = 1'b1;
				sel_lvl   = mlfq_pkg::LVL_W'(l);
			end
		end
	end

	// Active level count, clamped to the legal range.
	always_comb begin
		if (levels_q == 3'd0) begin
			k_act = 3'd1;
		end else if (levels_q > 3'(mlfq_pkg::MAX_LEVELS)) begin
			k_act = 3'(mlfq_pkg::MAX_LEVELS);
		end else begin
			k_act = levels_q;
		end
	end

	// Update of the job that runs on this tick.
	always_comb begin
		rem_n     = jrd_q.remaining - mlfq_pkg::BURST_BITS'(jrd_q.remaining != '0);
		used_n    = jrd_q.used + mlfq_pkg::USED_W'(jrd_q.used != '1);
		done_n    = (rem_n == '0);
		exhaust_n = (used_n >= allot_q[run_lvl_q]);
		if ((3'(run_lvl_q) + 3'd1) < k_act) begin
			new_lvl = run_lvl_q + 1'b1;
		end else begin
			new_lvl = mlfq_pkg::LVL_W'(k_act - 3'd1);
		end
	end

	// Memory address and write selection.
	always_comb begin
		q_we    = 1'b0;
		q_waddr = '0;
		q_wdata = '0;
		j_we    = 1'b0;
		j_waddr = slot_q;
		j_wdata = jrd_q;
		j_raddr = qrd_q;
		if (state_q == ST_BNEXT && blvl_q == '0) begin
			q_raddr = {mlfq_pkg::LVL_W'(0), head_q[0] + bidx_q[mlfq_pkg::SLOT_W-1:0]};
		end else if (state_q == ST_BNEXT) begin
			q_raddr = {walk_lvl, head_q[walk_lvl]};
		end else begin
			q_raddr = {sel_lvl, head_q[sel_lvl]};
		end
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && arrive_ok) begin
					q_we    = 1'b1;
					q_waddr = {mlfq_pkg::LVL_W'(0), tail0};
					q_wdata = free_slot;
					j_we    = 1'b1;
					j_waddr = free_slot;
					j_wdata = '{tag: job_tag, remaining: burst_length, used: '0,
						started: 1'b0};
				end else if (in_xfer && opcode == mlfq_pkg::OP_TICK && pend_valid_q) begin
					q_we    = 1'b1;
					q_waddr = {pend_lvl_q, head_q[pend_lvl_q] +
						cnt_q[pend_lvl_q][mlfq_pkg::SLOT_W-1:0]};
					q_wdata = pend_slot_q;
				end
			end
			ST_BWR: begin
				j_we         = 1'b1;
				j_wdata.used = '0;
				if (blvl_q != '0) begin
					q_we    = 1'b1;
					q_waddr = {mlfq_pkg::LVL_W'(0), tail0};
					q_wdata = slot_q;
				end
			end
			ST_RUN: begin
				if (ofree) begin
					j_we              = 1'b1;
					j_wdata.remaining = rem_n;
					j_wdata.used      = exhaust_n ? '0 : used_n;
					j_wdata.started   = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Queue memory: one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (q_we) qmem[q_waddr] <= q_wdata;
		qrd_q <= qmem[q_raddr];
	end

	// Job table memory: one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (j_we) jmem[j_waddr] <= j_wdata;
		jrd_q <= jmem[j_raddr];
	end

	// Sequencer, queue pointers, configuration and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			levels_q     <= 3'd3;
			allot_q[0]   <= 16'd4;
			allot_q[1]   <= 16'd8;
			allot_q[2]   <= 16'd16;
			allot_q[3]   <= 16'd32;
			period_q     <= 16'd30;
			countdown_q  <= 16'd30;
			for (int l = 0; l < mlfq_pkg::MAX_LEVELS; l++) begin
				head_q[l] <= '0;
				cnt_q[l]  <= '0;
			end
			busy_q       <= '0;
			pend_valid_q <= 1'b0;
			pend_slot_q  <= '0;
			pend_lvl_q   <= '0;
			time_q       <= '0;
			blvl_q       <= '0;
			bidx_q       <= '0;
			slot_q       <= '0;
			run_lvl_q    <= '0;
			out_valid    <= 1'b0;
			outcome      <= mlfq_pkg::OUT_ACCEPTED;
			run_tag      <= '0;
			run_level    <= '0;
			first_run    <= 1'b0;
			completed    <= 1'b0;
			demoted      <= 1'b0;
			tick_time    <= '0;
		end else begin
			if (out_valid && out_ready && !res_load) out_valid <= 1'b0;

			// Configuration writes; the boost counter reloads with its period.
			if (cfg_wr_en) begin
				case (cfg_index)
					mlfq_pkg::REG_LEVELS: levels_q   <= cfg_data[2:0];
					mlfq_pkg::REG_ALLOT0: allot_q[0] <= cfg_data;
					mlfq_pkg::REG_ALLOT1: allot_q[1] <= cfg_data;
					mlfq_pkg::REG_ALLOT2: allot_q[2] <= cfg_data;
					mlfq_pkg::REG_ALLOT3: allot_q[3] <= cfg_data;
					mlfq_pkg::REG_BOOST: begin
						period_q    <= cfg_data;
						countdown_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer && opcode == mlfq_pkg::OP_ARRIVE) begin
						out_valid <= 1'b1;
						run_tag   <= job_tag;
						run_level <= '0;
						first_run <= 1'b0;
						completed <= 1'b0;
						demoted   <= 1'b0;
						tick_time <= time_q;
						if (burst_length == '0) begin
							outcome <= mlfq_pkg::OUT_ZERO;
						end else if (table_full) begin
							outcome <= mlfq_pkg::OUT_FULL;
						end else begin
							outcome           <= mlfq_pkg::OUT_ACCEPTED;
							busy_q[free_slot] <= 1'b1;
							cnt_q[0]          <= cnt_q[0] + 1'b1;
						end
					end else if (in_xfer) begin
						// Requeue the job of the previous tick, then decide on a boost.
						if (pend_valid_q) begin
							cnt_q[pend_lvl_q] <= cnt_q[pend_lvl_q] + 1'b1;
							pend_valid_q      <= 1'b0;
						end
						if (period_q != '0 && countdown_q == '0) begin
							countdown_q <= period_q - 1'b1;
							blvl_q      <= '0;
							bidx_q      <= '0;
							state_q     <= ST_BNEXT;
						end else begin
							if (period_q != '0) countdown_q <= countdown_q - 1'b1;
							state_q <= ST_SEL;
						end
					end
				end
				ST_BNEXT: begin
					// Level 0 stays in place; deeper levels are drained onto its tail.
					if (blvl_q == '0) begin
						if (bidx_q < cnt_q[0]) begin
							state_q <= ST_BRDJ;
						end else begin
							blvl_q <= blvl_q + 1'b1;
						end
					end else if (blvl_q == mlfq_pkg::BLVL_W'(mlfq_pkg::MAX_LEVELS)) begin
						state_q <= ST_SEL;
					end else if (cnt_q[walk_lvl] != '0) begin
						head_q[walk_lvl] <= head_q[walk_lvl] + 1'b1;
						cnt_q[walk_lvl]  <= cnt_q[walk_lvl] - 1'b1;
						state_q          <= ST_BRDJ;
					end else begin
						blvl_q <= blvl_q + 1'b1;
					end
				end
				ST_BRDJ: begin
					slot_q  <= qrd_q;
					state_q <= ST_BWR;
				end
				ST_BWR: begin
					if (blvl_q == '0) begin
						bidx_q <= bidx_q + 1'b1;
					end else begin
						cnt_q[0] <= cnt_q[0] + 1'b1;
					end
					state_q <= ST_BNEXT;
				end
				ST_SEL: begin
					if (any_ready) begin
						head_q[sel_lvl] <= head_q[sel_lvl] + 1'b1;
						cnt_q[sel_lvl]  <= cnt_q[sel_lvl] - 1'b1;
						run_lvl_q       <= sel_lvl;
						state_q         <= ST_RRD;
					end else if (ofree) begin
						out_valid <= 1'b1;
						outcome   <= mlfq_pkg::OUT_IDLE;
						run_tag   <= '0;
						run_level <= '0;
						first_run <= 1'b0;
						completed <= 1'b0;
						demoted   <= 1'b0;
						tick_time <= time_q;
						time_q    <= time_q + 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				ST_RRD: begin
					slot_q  <= qrd_q;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (ofree) begin
						out_valid <= 1'b1;
						outcome   <= mlfq_pkg::OUT_RAN;
						run_tag   <= jrd_q.tag;
						run_level <= run_lvl_q;
						first_run <= !jrd_q.started;
						completed <= done_n;
						demoted   <= !done_n && exhaust_n;
						tick_time <= time_q;
						time_q    <= time_q + 1'b1;
						if (done_n) begin
							busy_q[slot_q] <= 1'b0;
						end else begin
							pend_valid_q <= 1'b1;
							pend_slot_q  <= slot_q;
							pend_lvl_q   <= exhaust_n ? new_lvl : run_lvl_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> sv/mlfq_checker.sv
// Port-level checks of the scheduler and their binding to the top level.
module mlfq_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [2:0]                      outcome,
	input logic [mlfq_pkg::TAG_W-1:0]      run_tag,
	input logic [mlfq_pkg::LVL_W-1:0]      run_level,
	input logic                            first_run,
	input logic                            completed,
	input logic                            demoted
);

	// A stalled result stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its outcome and tag.
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(outcome) && $stable(run_tag))
		else $error("result changed while stalled");

	// Only a job that ran can finish or be demoted, never both at once.
	a_ran: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (completed || demoted) |-> outcome == mlfq_pkg::OUT_RAN &&
		!(completed && demoted))
		else $error("completion flags on a result where no job ran");

	// Arrive and idle results carry no run information.
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome == mlfq_pkg::OUT_IDLE || outcome == mlfq_pkg::OUT_ACCEPTED ||
		outcome == mlfq_pkg::OUT_FULL || outcome == mlfq_pkg::OUT_ZERO) |->
		!first_run && run_level == '0)
		else $error("run fields set on a result where no job ran");

endmodule

bind multilevel_feedback_queue_scheduler mlfq_checker u_mlfq_checker (.*);
